// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define SRLD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is high.
`define SRLD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define SRLD_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/srld_pkg.sv =====
package srld_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [9:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       status;
    logic       run_end;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RUN    = 2'd1,
    PH_PIXEL  = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_DONE    = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  localparam logic [16:0] LEN_LO_POS   = 17'd3;
  localparam logic [16:0] LEN_HI_POS   = 17'd4;
  localparam logic [16:0] HEADER_BYTES = 17'd5;
  localparam logic [16:0] POS_MAX      = 17'h1FFFF;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

  // Result queue: two free slots are needed to take the next request.
  localparam int OUTQ_DEPTH = 4;

endpackage

// ===== hdl/srld_decode.sv =====
module srld_decode #(
  parameter int SPRITE_SIZE = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  use_alpha,
  input  logic                  step,
  input  srld_pkg::in_item_t    item,
  output srld_pkg::out_item_t   res0,
  output srld_pkg::out_item_t   res1,
  output logic [1:0]            res_count
);

  localparam int TOTAL = SPRITE_SIZE * SPRITE_SIZE;
  localparam int PW    = $clog2(TOTAL + 1);
  localparam logic [PW-1:0] TOTAL_P = PW'(TOTAL);

  srld_pkg::phase_t phase, phase_next;
  logic [16:0]   byte_position, byte_position_next;
  logic [16:0]   payload_end, payload_end_next;
  logic [7:0]    low_byte_hold, low_byte_hold_next;
  logic [15:0]   colored_left, colored_left_next;
  logic [PW-1:0] pixel_position, pixel_position_next;
  logic [23:0]   color_hold, color_hold_next;
  logic [1:0]    byte_in_pixel, byte_in_pixel_next;

  logic [7:0]    b;
  logic          fin;
  logic          in_payload;
  logic [16:0]   run_sum;
  logic [15:0]   count_word;
  logic [23:0]   color_mix;
  logic          pixel_done;
  logic [PW-1:0] pixel_inc;
  logic [15:0]   colored_dec;
  logic          emit;
  logic [16:0]   pix_ext;
  srld_pkg::out_item_t pix_res, done_res;

  assign b          = item.data_byte;
  assign fin        = item.final_byte;
  assign in_payload = byte_position < payload_end;
  assign count_word = {b, low_byte_hold};
  assign run_sum    = 17'(pixel_position) + {1'b0, count_word};
  assign pixel_inc  = pixel_position + PW'(1);
  assign colored_dec = colored_left - 16'd1;
  assign pix_ext    = 17'(pixel_position);
  assign pixel_done = use_alpha ? (byte_in_pixel == 2'd3) : (byte_in_pixel >= 2'd2);

  always_comb begin
    color_mix = color_hold;
    case (byte_in_pixel)
      2'd0: color_mix[7:0]   = color_hold[7:0] | b;
      2'd1: color_mix[15:8]  = color_hold[15:8] | b;
      2'd2: color_mix[23:16] = color_hold[23:16] | b;
      default: color_mix = color_hold;
    endcase
  end

  always_comb begin
    phase_next          = phase;
    payload_end_next    = payload_end;
    low_byte_hold_next  = low_byte_hold;
    colored_left_next   = colored_left;
    pixel_position_next = pixel_position;
    color_hold_next     = color_hold;
    byte_in_pixel_next  = byte_in_pixel;
    emit                = 1'b0;

    case (phase)
      srld_pkg::PH_HEADER: begin
        if (byte_position == srld_pkg::LEN_LO_POS) begin
          low_byte_hold_next = b;
        end else if (byte_position == srld_pkg::LEN_HI_POS) begin
          payload_end_next   = srld_pkg::HEADER_BYTES + {1'b0, count_word};
          phase_next         = srld_pkg::PH_RUN;
          byte_in_pixel_next = 2'd0;
        end
      end
      srld_pkg::PH_RUN: begin
        if (in_payload) begin
          case (byte_in_pixel)
            2'd0: begin
              low_byte_hold_next = b;
              byte_in_pixel_next = 2'd1;
            end
            2'd1: begin
              // transparent run, clamped at the image size
              pixel_position_next = (run_sum > 17'(TOTAL)) ? TOTAL_P : PW'(run_sum);
              byte_in_pixel_next  = 2'd2;
            end
            2'd2: begin
              low_byte_hold_next = b;
              byte_in_pixel_next = 2'd3;
            end
            default: begin
              colored_left_next  = count_word;
              byte_in_pixel_next = 2'd0;
              color_hold_next    = '0;
              if (pixel_position >= TOTAL_P) begin
                phase_next = srld_pkg::PH_STOP;
              end else if (count_word != 16'd0) begin
                phase_next = srld_pkg::PH_PIXEL;
              end
            end
          endcase
        end
      end
      srld_pkg::PH_PIXEL: begin
        if (in_payload) begin
          if (pixel_done) begin
            emit                = 1'b1;
            pixel_position_next = pixel_inc;
            colored_left_next   = colored_dec;
            color_hold_next     = '0;
            byte_in_pixel_next  = 2'd0;
            if (pixel_inc >= TOTAL_P) begin
              phase_next = srld_pkg::PH_STOP;
            end else if (colored_dec == 16'd0) begin
              phase_next = srld_pkg::PH_RUN;
            end
          end else begin
            color_hold_next    = color_mix;
            byte_in_pixel_next = byte_in_pixel + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase

    byte_position_next = (byte_position < srld_pkg::POS_MAX) ?
                         byte_position + 17'd1 : byte_position;

    // done record: next byte starts a fresh sprite
    if (fin) begin
      phase_next          = srld_pkg::PH_HEADER;
      byte_position_next  = '0;
      payload_end_next    = '0;
      low_byte_hold_next  = '0;
      colored_left_next   = '0;
      pixel_position_next = '0;
      color_hold_next     = '0;
      byte_in_pixel_next  = '0;
    end
  end

  always_comb begin
    pix_res             = '0;
    pix_res.kind        = srld_pkg::KIND_PIXEL;
    pix_res.pixel_index = pix_ext[9:0];
    pix_res.red         = color_mix[7:0];
    pix_res.green       = color_mix[15:8];
    pix_res.blue        = color_mix[23:16];
    pix_res.alpha       = (use_alpha && byte_in_pixel == 2'd3) ? b : srld_pkg::ALPHA_OPAQUE;
    pix_res.status      = srld_pkg::STATUS_OK;
    pix_res.run_end     = !fin;

    done_res         = '0;
    done_res.kind    = srld_pkg::KIND_DONE;
    done_res.status  = (byte_position < srld_pkg::LEN_HI_POS) ?
                       srld_pkg::STATUS_SHORT : srld_pkg::STATUS_OK;
    done_res.run_end = 1'b1;

    res0      = emit ? pix_res : done_res;
    res1      = done_res;
    res_count = {1'b0, emit} + {1'b0, fin};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= srld_pkg::PH_HEADER;
      byte_position  <= '0;
      payload_end    <= '0;
      low_byte_hold  <= '0;
      colored_left   <= '0;
      pixel_position <= '0;
      color_hold     <= '0;
      byte_in_pixel  <= '0;
    end else if (step) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      payload_end    <= payload_end_next;
      low_byte_hold  <= low_byte_hold_next;
      colored_left   <= colored_left_next;
      pixel_position <= pixel_position_next;
      color_hold     <= color_hold_next;
      byte_in_pixel  <= byte_in_pixel_next;
    end
  end

endmodule

// ===== hdl/srld_outq.sv =====
module srld_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push_count,
  input  srld_pkg::out_item_t  push0,
  input  srld_pkg::out_item_t  push1,
  input  logic                 pop,
  output logic                 has_room,
  output logic                 not_empty,
  output srld_pkg::out_item_t  head
);

  localparam int AW = $clog2(srld_pkg::OUTQ_DEPTH);
  localparam int CW = $clog2(srld_pkg::OUTQ_DEPTH + 1);

  srld_pkg::out_item_t mem [srld_pkg::OUTQ_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic [AW-1:0] wr_ptr_inc;

  assign wr_ptr_inc = wr_ptr + AW'(1);
  assign has_room   = count <= CW'(srld_pkg::OUTQ_DEPTH - 2);
  assign not_empty  = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_inc] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + CW'(push_count) - CW'(pop);
    end
  end

endmodule

// ===== hdl/sprite_run_length_decoder_top.sv =====
// Run-length sprite decoder.
// Input channel (in_valid / in_stall / in_data): one encoded byte per request,
// with final_byte marking the last byte of a sprite. Bytes 0..2 are skipped,
// bytes 3..4 give the little-endian payload length, then transparent and
// colored runs follow.
// Output channel (out_valid / out_stall / out_data): pixel writes (kind 0)
// carrying the linear index and RGBA, and one done record (kind 1) after the
// final byte with status 0 ok or 1 short header. run_end marks the last
// result caused by a byte.
// cfg_write / cfg_data set use_alpha (4 bytes per pixel when 1, else 3 and
// alpha 255); write only while the block is idle.
// Throughput: one byte per cycle while the queue has room for two results;
// the decode state updates in one pass per byte. A final byte that also
// completes a pixel pushes two results, and the 4-entry result queue drains
// them at one per cycle while out_stall is low. An accepted request is held in
// the input register, then decoded into the queue, whose head drives out_data.
// Receiver stall: results collect in the queue; in_stall is high while a byte
// is held and fewer than two queue slots are free. Reset (rst, synchronous)
// empties the queue, drops the held byte and returns to the start of a sprite
// with use_alpha 0.
module sprite_run_length_decoder_top #(
  parameter int SPRITE_SIZE = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  srld_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srld_pkg::out_item_t out_data
);

  logic                use_alpha;
  logic                hold_valid;
  srld_pkg::in_item_t  hold_item;
  logic                go;
  logic                has_room;
  logic [1:0]          res_count;
  logic [1:0]          push_count;
  srld_pkg::out_item_t res0, res1;

  // held byte is decoded once the queue can absorb two results
  assign go         = hold_valid && has_room;
  assign in_stall   = hold_valid && !has_room;
  assign push_count = go ? res_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_alpha <= 1'b0;
    end else if (cfg_write) begin
      use_alpha <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_item <= in_data;
    end
  end

  srld_decode #(
    .SPRITE_SIZE (SPRITE_SIZE)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .use_alpha (use_alpha),
    .step      (go),
    .item      (hold_item),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  srld_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .pop        (out_valid && !out_stall),
    .has_room   (has_room),
    .not_empty  (out_valid),
    .head       (out_data)
  );

endmodule

// ===== hdl/srld_checker.sv =====
`include "assert_macros.svh"

module srld_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input srld_pkg::out_item_t out_data
);

  logic done_clean;

  assign done_clean = out_data.run_end && out_data.pixel_index == 10'd0 &&
                      out_data.red == 8'd0 && out_data.green == 8'd0 &&
                      out_data.blue == 8'd0 && out_data.alpha == 8'd0;

  `SRLD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, $stable(out_data))

  `SRLD_ASSERT_IMP(a_done_form, clk, rst, out_valid && out_data.kind == srld_pkg::KIND_DONE, done_clean)

  `SRLD_ASSERT_IMP(a_pixel_status, clk, rst, out_valid && out_data.kind == srld_pkg::KIND_PIXEL, out_data.status == srld_pkg::STATUS_OK)

  `SRLD_ASSERT_NXT_ALWAYS(a_reset_idle, clk, rst, !out_valid && !in_stall)

endmodule

bind sprite_run_length_decoder_top srld_checker u_srld_checker (.*);

// ===== sim/tb_top.sv =====
module tb_top;

  // Sprite edge in pixels; must match the DUT parameter.
  localparam int SPRITE_SIZE = 32;
  localparam int PIX_TOTAL   = SPRITE_SIZE * SPRITE_SIZE;
  localparam int PIX_W       = $clog2(PIX_TOTAL) + 1;
  localparam logic [PIX_W-1:0] PIX_FULL = PIX_W'(PIX_TOTAL);

  // Random part stops once about this many bytes have been requested.
  localparam int RANDOM_ITEMS = 1500;
  // use_alpha flips every this many random bytes.
  localparam int CFG_BLOCK    = 300;
  localparam int DIR_ROWS     = 27;

  typedef logic [7:0] byte_q_t [$];

  // One row of the directed table. typed_n is the number of results typed in
  // below for this row; zero means the predictor supplies them.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       cfg_en;
    logic       cfg_val;
    logic [1:0] typed_n;
  } row_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                cfg_write = 1'b0;
  logic                cfg_data  = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  srld_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  srld_pkg::out_item_t out_data;

  sprite_run_length_decoder_top #(
    .SPRITE_SIZE(SPRITE_SIZE)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: sized from the slowest legal run (long gaps and stalls on
  // every request, two results per byte) times several.
  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the decode state and of use_alpha.
  // ---------------------------------------------------------------------------
  logic             alpha_mode;
  srld_pkg::phase_t dec_phase;
  logic [16:0]      byte_pos;
  logic [16:0]      pay_end;
  logic [7:0]       low_hold;
  logic [15:0]      colored_left;
  logic [PIX_W-1:0] pix_pos;
  logic [23:0]      color_acc;
  logic [1:0]       sub_byte;

  srld_pkg::out_item_t byte_records [$];      // results of the byte just decoded
  srld_pkg::out_item_t expected_records [$];  // results still owed by the DUT
  srld_pkg::out_item_t typed_results [$];     // hand-written results for directed rows

  int errors    = 0;
  int fed_count = 0;
  bit calm      = 1'b0;             // no gaps and no stalls while set

  function automatic void clear_decoder();
    dec_phase    = srld_pkg::PH_HEADER;
    byte_pos     = '0;
    pay_end      = '0;
    low_hold     = '0;
    colored_left = '0;
    pix_pos      = '0;
    color_acc    = '0;
    sub_byte     = '0;
  endfunction

  function automatic srld_pkg::out_item_t pix_rec(input logic [9:0] idx,
                                                  input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b,
                                                  input logic [7:0] a,
                                                  input logic last);
    srld_pkg::out_item_t o;
    o             = '0;
    o.kind        = srld_pkg::KIND_PIXEL;
    o.pixel_index = idx;
    o.red         = r;
    o.green       = g;
    o.blue        = b;
    o.alpha       = a;
    o.status      = srld_pkg::STATUS_OK;
    o.run_end     = last;
    return o;
  endfunction

  function automatic srld_pkg::out_item_t done_rec(input logic status);
    srld_pkg::out_item_t o;
    o         = '0;
    o.kind    = srld_pkg::KIND_DONE;
    o.status  = status;
    o.run_end = 1'b1;
    return o;
  endfunction

  // Decode one accepted byte; leaves its results in byte_records.
  function automatic void decode_byte(input srld_pkg::in_item_t it);
    logic [16:0] at;
    logic [16:0] run_sum;
    logic [7:0]  v;
    int          need;
    int          sub;
    byte_records.delete();
    v  = it.data_byte;
    at = byte_pos;
    if (dec_phase == srld_pkg::PH_HEADER) begin
      if (at == srld_pkg::LEN_LO_POS) begin
        low_hold = v;
      end else if (at == srld_pkg::LEN_HI_POS) begin
        pay_end   = srld_pkg::HEADER_BYTES + {1'b0, v, low_hold};
        dec_phase = srld_pkg::PH_RUN;
        sub_byte  = '0;
      end
    end else if (dec_phase != srld_pkg::PH_STOP && at < pay_end) begin
      if (dec_phase == srld_pkg::PH_RUN) begin
        // run header: transparent count (lo, hi), then colored count (lo, hi)
        case (sub_byte)
          2'd0, 2'd2: begin
            low_hold = v;
            sub_byte = sub_byte + 2'd1;
          end
          2'd1: begin
            run_sum  = 17'(pix_pos) + {1'b0, v, low_hold};
            pix_pos  = (run_sum > 17'(PIX_TOTAL)) ? PIX_FULL : PIX_W'(run_sum);
            sub_byte = 2'd2;
          end
          default: begin
            colored_left = {v, low_hold};
            sub_byte     = '0;
            color_acc    = '0;
            if (pix_pos >= PIX_FULL) dec_phase = srld_pkg::PH_STOP;
            else if (colored_left != 16'd0) dec_phase = srld_pkg::PH_PIXEL;
          end
        endcase
      end else begin
        // pixel size follows use_alpha as it stands at this byte
        need = alpha_mode ? 4 : 3;
        sub  = int'(sub_byte);
        if (sub < 3) color_acc = color_acc | (24'(v) << (8 * sub));
        if (sub + 1 >= need) begin
          byte_records = {byte_records,
                          pix_rec(pix_pos[9:0], color_acc[7:0], color_acc[15:8],
                                  color_acc[23:16],
                                  (alpha_mode && sub == 3) ? v : srld_pkg::ALPHA_OPAQUE,
                                  !it.final_byte)};
          pix_pos      = pix_pos + PIX_W'(1);
          colored_left = colored_left - 16'd1;
          color_acc    = '0;
          sub_byte     = '0;
          if (pix_pos >= PIX_FULL) dec_phase = srld_pkg::PH_STOP;
          else if (colored_left == 16'd0) dec_phase = srld_pkg::PH_RUN;
        end else begin
          sub_byte = 2'(sub + 1);
        end
      end
    end
    if (byte_pos < srld_pkg::POS_MAX) byte_pos = byte_pos + 17'd1;
    if (it.final_byte) begin
      byte_records = {byte_records,
                      done_rec((at < srld_pkg::LEN_HI_POS) ?
                               srld_pkg::STATUS_SHORT : srld_pkg::STATUS_OK)};
      clear_decoder();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_record(input srld_pkg::out_item_t got,
                              input srld_pkg::out_item_t want);
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      errors++;
    end
    if (got.pixel_index !== want.pixel_index) begin
      $error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
      errors++;
    end
    if (got.red !== want.red) begin
      $error("red: expected %0d, got %0d", want.red, got.red);
      errors++;
    end
    if (got.green !== want.green) begin
      $error("green: expected %0d, got %0d", want.green, got.green);
      errors++;
    end
    if (got.blue !== want.blue) begin
      $error("blue: expected %0d, got %0d", want.blue, got.blue);
      errors++;
    end
    if (got.alpha !== want.alpha) begin
      $error("alpha: expected %0d, got %0d", want.alpha, got.alpha);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.run_end !== want.run_end) begin
      $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
      errors++;
    end
  endtask

  // Values read right after the edge are the ones the DUT saw at that edge.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_records.size() == 0) begin
        $error("result with nothing expected: kind %0d index %0d",
               out_data.kind, out_data.pixel_index);
        errors++;
      end else begin
        check_record(out_data, expected_records.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idle lengths for request gaps and receiver stalls, with an occasional long one.
  // ---------------------------------------------------------------------------
  function automatic int hold_len();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(10, 30));
    return int'($urandom_range(1, 3));
  endfunction

  // Receiver back-pressure.
  int stall_left = 0;
  always @(posedge clk) begin
    if (calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = hold_len();
    end
  end

  // Present one request and hold it until accepted. Returns in the time step
  // of the accepting edge; valid stays high when the next request follows
  // without a gap.
  task automatic send(input srld_pkg::in_item_t it);
    int gap;
    gap = calm ? 0 : (($urandom_range(0, 2) == 0) ? hold_len() : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Write use_alpha once the DUT has drained. A byte may still be in the
  // input register without owing a result, so also let it pass the decoder.
  task automatic set_alpha(input logic v);
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    alpha_mode = v;
  endtask

  task automatic feed(input srld_pkg::in_item_t it);
    send(it);
    decode_byte(it);
    expected_records = {expected_records, byte_records};
    fed_count++;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Send a byte sequence, final mark on its last byte (on random ones too if
  // stray_finals). A rare use_alpha flip lands mid-sprite, often mid-pixel.
  task automatic feed_sprite(input byte_q_t s, input bit stray_finals);
    srld_pkg::in_item_t it;
    for (int i = 0; i < s.size(); i++) begin
      if ($urandom_range(0, 199) == 0) set_alpha(~alpha_mode);
      it.data_byte  = s[i];
      it.final_byte = (i == s.size() - 1) || (stray_finals && $urandom_range(0, 7) == 0);
      feed(it);
    end
  endtask

  // Well-formed sprite with random content: a few runs, counts biased toward
  // small values with some near the image edge and some at the maximum.
  // Sometimes the length field or the final mark cuts it short or leaves
  // extra bytes.
  task automatic build_sprite(output byte_q_t s);
    byte_q_t     body;
    int          pix;
    int          bpp;
    int          cut;
    logic [15:0] clear_n;
    logic [15:0] paint_n;
    logic [15:0] len_field;
    body = {};
    s    = {};
    bpp  = alpha_mode ? 4 : 3;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 19))
        0:       clear_n = 16'hFFFF;
        1, 2:    clear_n = 16'($urandom_range(1000, 1030));
        3, 4:    clear_n = 16'($urandom_range(0, 1100));
        default: clear_n = 16'($urandom_range(0, 20));
      endcase
      case ($urandom_range(0, 19))
        0:       paint_n = 16'hFFFF;
        1, 2:    paint_n = 16'($urandom_range(6, 40));
        default: paint_n = 16'($urandom_range(0, 5));
      endcase
      pix = (paint_n > 16'd40) ? int'($urandom_range(0, 4)) : int'(paint_n);
      body = {body, clear_n[7:0], clear_n[15:8], paint_n[7:0], paint_n[15:8]};
      repeat (pix * bpp) body = {body, rand_byte()};
    end
    case ($urandom_range(0, 19))
      0:       len_field = 16'hFFFF;
      1, 2:    len_field = 16'($urandom_range(0, body.size()));
      3:       len_field = 16'(body.size() + int'($urandom_range(1, 8)));
      default: len_field = 16'(body.size());
    endcase
    repeat (3) s = {s, rand_byte()};
    s = {s, len_field[7:0], len_field[15:8]};
    s = {s, body};
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) s = {s, rand_byte()};
    if ($urandom_range(0, 9) == 0) begin
      cut = int'($urandom_range(5, s.size()));
      s   = s[0:cut-1];
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table.
  // ---------------------------------------------------------------------------
  row_t dir_tab [DIR_ROWS] = '{
    // lone final byte right after reset: header too short
    '{8'h00, 1'b1, 1'b0, 1'b0, 2'd1},
    // max length, transparent run to the last pixel, colored count at max;
    // the pixel fills the image, so the trailing byte is ignored
    '{8'h00, 1'b0, 1'b0, 1'b0, 2'd0}, '{8'h7F, 1'b0, 1'b0, 1'b0, 2'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 2'd0}, '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0}, '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0},
    '{8'h03, 1'b0, 1'b0, 1'b0, 2'd0}, '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0}, '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0}, '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd1},
    '{8'h5A, 1'b1, 1'b0, 1'b0, 2'd1},
    // alpha mode: one RGBA pixel at index 0 with alpha 0, completed by the
    // final byte, so the pixel write comes before the done record
    '{8'h01, 1'b0, 1'b1, 1'b1, 2'd0}, '{8'h02, 1'b0, 1'b0, 1'b0, 2'd0},
    '{8'h03, 1'b0, 1'b0, 1'b0, 2'd0}, '{8'h08, 1'b0, 1'b0, 1'b0, 2'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 1'b0, 2'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 2'd0}, '{8'h01, 1'b0, 1'b0, 1'b0, 2'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 2'd0}, '{8'h12, 1'b0, 1'b0, 1'b0, 2'd0},
    '{8'h34, 1'b0, 1'b0, 1'b0, 2'd0}, '{8'h56, 1'b0, 1'b0, 1'b0, 2'd0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 2'd2}
  };

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    srld_pkg::in_item_t row_item;
    byte_q_t            s;
    int                 blk;

    alpha_mode = 1'b0;
    clear_decoder();

    // hand-written results, in the order their rows appear
    typed_results = {typed_results, done_rec(srld_pkg::STATUS_SHORT)};
    typed_results = {typed_results,
                     pix_rec(10'h3FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1)};
    typed_results = {typed_results, done_rec(srld_pkg::STATUS_OK)};
    typed_results = {typed_results,
                     pix_rec(10'd0, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0)};
    typed_results = {typed_results, done_rec(srld_pkg::STATUS_OK)};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].cfg_en) set_alpha(dir_tab[r].cfg_val);
      row_item.data_byte  = dir_tab[r].data;
      row_item.final_byte = dir_tab[r].fin;
      if (dir_tab[r].typed_n == 2'd0) begin
        feed(row_item);
      end else begin
        send(row_item);
        decode_byte(row_item);   // keeps the predictor state in step
        repeat (int'(dir_tab[r].typed_n))
          expected_records = {expected_records, typed_results.pop_front()};
      end
    end

    // Random part: mostly well-formed sprites, some short headers and noise.
    fed_count = 0;
    blk       = 0;
    while (fed_count < RANDOM_ITEMS) begin
      if (fed_count >= blk * CFG_BLOCK) begin
        set_alpha(1'(blk % 2));
        blk++;
      end
      calm = ($urandom_range(0, 4) == 0);
      s    = {};
      case ($urandom_range(0, 19))
        0: begin
          repeat ($urandom_range(1, 4)) s = {s, rand_byte()};
          feed_sprite(s, 1'b0);
        end
        1: begin
          repeat ($urandom_range(1, 30)) s = {s, rand_byte()};
          feed_sprite(s, 1'b1);
        end
        default: begin
          build_sprite(s);
          feed_sprite(s, 1'b0);
        end
      endcase
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    // catch anything extra still coming out of the pipeline
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sprite_run_length_decoder_top.f =====
+incdir+hdl
hdl/srld_pkg.sv
hdl/srld_decode.sv
hdl/srld_outq.sv
hdl/sprite_run_length_decoder_top.sv
hdl/srld_checker.sv
sim/tb_top.sv
